### hdl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define ASSERT_CLK_RST(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("%m: assertion failed");

// Clocked assertion that is also checked during reset.
`define ASSERT_CLK(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("%m: assertion failed");

`endif

### hdl/aes128e_pkg.sv
// Shared types, constants and round functions for the AES-128 encrypt pipeline.
package aes128e_pkg;

	localparam int NUM_ROUNDS = 10;
	localparam int HALF_W     = 64;
	localparam int BLK_W      = 2 * HALF_W;
	localparam int CFG_IDX_W  = 1;

	typedef logic [BLK_W-1:0] block_t;
	typedef logic [7:0]       byte_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KEY_HIGH = 1'b0,
		REG_KEY_LOW  = 1'b1
	} cfg_reg_t;

	localparam byte_t GF_POLY  = 8'h1b;
	localparam byte_t RC_FIRST = 8'h01;

	localparam byte_t SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	// GF(2^8) multiply by x.
	function automatic byte_t xtime(byte_t x);
		return {x[6:0], 1'b0} ^ (x[7] ? GF_POLY : 8'h00);
	endfunction

	// Round constant for round r (1..NUM_ROUNDS); elaboration-time only.
	function automatic byte_t rcon(int r);
		byte_t rc;
		rc = RC_FIRST;
		for (int i = 1; i < r; i++)
			rc = xtime(rc);
		return rc;
	endfunction

	// Byte i of a block, byte 0 in the top bits.
	function automatic byte_t get_byte(block_t b, int i);
		return b[BLK_W-1-8*i -: 8];
	endfunction

	// SubBytes then ShiftRows.
	function automatic block_t sub_shift(block_t s);
		block_t t;
		for (int c = 0; c < 4; c++)
			for (int r = 0; r < 4; r++)
				t[BLK_W-1-8*(4*c+r) -: 8] = SBOX[get_byte(s, 4*((c+r)%4) + r)];
		return t;
	endfunction

	function automatic block_t mix_columns(block_t s);
		block_t t;
		byte_t  a0, a1, a2, a3, all;
		for (int c = 0; c < 4; c++) begin
			a0  = get_byte(s, 4*c);
			a1  = get_byte(s, 4*c+1);
			a2  = get_byte(s, 4*c+2);
			a3  = get_byte(s, 4*c+3);
			all = a0 ^ a1 ^ a2 ^ a3;
			t[BLK_W-1-8*(4*c)   -: 8] = a0 ^ all ^ xtime(a0 ^ a1);
			t[BLK_W-1-8*(4*c+1) -: 8] = a1 ^ all ^ xtime(a1 ^ a2);
			t[BLK_W-1-8*(4*c+2) -: 8] = a2 ^ all ^ xtime(a2 ^ a3);
			t[BLK_W-1-8*(4*c+3) -: 8] = a3 ^ all ^ xtime(a3 ^ a0);
		end
		return t;
	endfunction

	// One step of the key schedule: RotWord, SubWord, Rcon, then the word chain.
	function automatic block_t round_key_step(block_t k, byte_t rc);
		logic [31:0] g, w0, w1, w2, w3;
		g  = {SBOX[get_byte(k, 13)] ^ rc, SBOX[get_byte(k, 14)],
		      SBOX[get_byte(k, 15)], SBOX[get_byte(k, 12)]};
		w0 = k[127:96] ^ g;
		w1 = k[95:64] ^ w0;
		w2 = k[63:32] ^ w1;
		w3 = k[31:0] ^ w2;
		return {w0, w1, w2, w3};
	endfunction

endpackage

### hdl/aes128e_round_cell.sv
// One AES round cell: round logic plus its pipeline register and handshake.
module aes128e_round_cell #(
	parameter int ROUND = 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  aes128e_pkg::block_t   in_state,
	input  aes128e_pkg::block_t   in_key,
	output logic                  out_valid,
	input  logic                  out_ready,
	output aes128e_pkg::block_t   out_state,
	output aes128e_pkg::block_t   out_key
);
	import aes128e_pkg::*;

	localparam byte_t RC = rcon(ROUND);

	logic   valid_q;
	block_t state_q;
	block_t key_q;
	block_t sb;
	block_t mixed;
	block_t nk;

	always_comb begin
		sb    = sub_shift(in_state);
		mixed = (ROUND == NUM_ROUNDS) ? sb : mix_columns(sb);
		nk    = round_key_step(in_key, RC);
	end

	// Stage may load when empty or when its content moves on this cycle.
	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			state_q <= mixed ^ nk;
			key_q   <= nk;
		end
	end

	assign out_valid = valid_q;
	assign out_state = state_q;
	assign out_key   = key_q;

endmodule

### hdl/aes128_block_encrypt_unit.sv
// Top level of the AES-128 block encrypt pipeline.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+-------------------------------------
//  config   | cfg_wr_en             | cfg_index, cfg_data (key halves)
//  input    | in_valid / in_ready   | plain_high, plain_low
//  output   | out_valid / out_ready | cipher_high, cipher_low
//
// One block per cycle sustained while the output is not stalled; the pipeline is the
// initial key XOR register plus one register per round cell, the last cell being the output register.
// Round keys travel down the chain with each block, each cell deriving the next one.
// Reset clears the stage valid bits and the key registers to zero.
// Each stage stalls only when it is full and its successor cannot take its data, so
// bubbles collapse and new blocks keep entering while a finished result waits.
module aes128_block_encrypt_unit (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_wr_en,
	input  logic [aes128e_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [aes128e_pkg::HALF_W-1:0]         cfg_data,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic [aes128e_pkg::HALF_W-1:0]         plain_high,
	input  logic [aes128e_pkg::HALF_W-1:0]         plain_low,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic [aes128e_pkg::HALF_W-1:0]         cipher_high,
	output logic [aes128e_pkg::HALF_W-1:0]         cipher_low
);
	import aes128e_pkg::*;

	// Cipher key registers; the user must write them only while the pipeline is drained (not enforced here).
	logic [HALF_W-1:0] key_high_q;
	logic [HALF_W-1:0] key_low_q;

	// Per-stage handshake and payload; index 0 is the key XOR stage.
	logic   stage_vld   [NUM_ROUNDS+1];
	block_t stage_state [NUM_ROUNDS+1];
	block_t stage_key   [NUM_ROUNDS+1];
	logic   stage_rdy   [NUM_ROUNDS+2];

	logic   valid_s0;
	block_t state_s0;
	block_t key_s0;

	// Config decode.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q  <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_KEY_HIGH: key_high_q <= cfg_data;
				REG_KEY_LOW:  key_low_q  <= cfg_data;
			endcase
		end
	end

	// Stage 0: initial AddRoundKey with the cipher key.
	assign stage_rdy[0] = !valid_s0 || stage_rdy[1];
	assign in_ready     = stage_rdy[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s0 <= 1'b0;
		end else if (stage_rdy[0]) begin
			valid_s0 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && stage_rdy[0]) begin
			state_s0 <= {plain_high, plain_low} ^ {key_high_q, key_low_q};
			key_s0   <= {key_high_q, key_low_q};
		end
	end

	assign stage_vld[0]   = valid_s0;
	assign stage_state[0] = state_s0;
	assign stage_key[0]   = key_s0;

	// Round cells 1..NUM_ROUNDS; the last skips MixColumns.
	for (genvar r = 1; r <= NUM_ROUNDS; r++) begin : g_round
		aes128e_round_cell #(
			.ROUND (r)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (stage_vld[r-1]),
			.in_ready  (stage_rdy[r]),
			.in_state  (stage_state[r-1]),
			.in_key    (stage_key[r-1]),
			.out_valid (stage_vld[r]),
			.out_ready (stage_rdy[r+1]),
			.out_state (stage_state[r]),
			.out_key   (stage_key[r])
		);
	end

	// Last cell register is the output register.
	assign stage_rdy[NUM_ROUNDS+1] = out_ready;
	assign out_valid   = stage_vld[NUM_ROUNDS];
	assign cipher_high = stage_state[NUM_ROUNDS][BLK_W-1:HALF_W];
	assign cipher_low  = stage_state[NUM_ROUNDS][HALF_W-1:0];

endmodule

### hdl/aes128e_checker.sv
// Port-level checker for the AES-128 encrypt unit, bound to the top level.
`include "assert_macros.svh"

module aes128e_checker (
	input logic                                   clk,
	input logic                                   arst_n,
	input logic                                   in_valid,
	input logic                                   in_ready,
	input logic                                   out_valid,
	input logic                                   out_ready,
	input logic [aes128e_pkg::HALF_W-1:0]         cipher_high,
	input logic [aes128e_pkg::HALF_W-1:0]         cipher_low
);
	import aes128e_pkg::*;

	localparam int LATENCY = NUM_ROUNDS + 1;

	// Stalled result keeps its valid and its data.
	`ASSERT_CLK_RST(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid)
	`ASSERT_CLK_RST(a_out_stable, clk, arst_n, out_valid && !out_ready |=> $stable(cipher_high) && $stable(cipher_low))
	// A clock edge under reset leaves the output empty.
	`ASSERT_CLK(a_rst_empty, clk, !arst_n |=> !out_valid)
	// Free output side means the whole chain can move, so input is open.
	`ASSERT_CLK_RST(a_in_open, clk, arst_n, (!out_valid || out_ready) |-> in_ready)
	// A transfer in is followed by a result (or a full stalled chain) after the latency.
	`ASSERT_CLK_RST(a_latency, clk, arst_n, in_valid && in_ready |-> ##LATENCY out_valid)

endmodule

bind aes128_block_encrypt_unit aes128e_checker u_aes128e_checker (.*);
